// ----- rtl/reactive_power_split_limiter_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef REACTIVE_POWER_SPLIT_LIMITER_ASSERT_SVH
`define REACTIVE_POWER_SPLIT_LIMITER_ASSERT_SVH
`ifndef SYNTH
`define RPSL_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RPSL_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPSL_ASSERT(label, clk, rstn, prop, msg)
`define RPSL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/rpsl_pkg.sv -----
package rpsl_pkg;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned NumLanes    = 4;
  localparam logic [14:0] FullReset   = 15'd2500;
  localparam logic [14:0] HalfReset   = 15'd1250;
  localparam logic [0:0]  RegFull     = 1'b0;
  localparam logic [0:0]  RegHalf     = 1'b1;
  localparam logic [1:0]  DerateAll   = 2'b11;

  // Lane control handed to the merge stage.
  typedef struct packed {
    logic valid;
    logic avail;
  } lane_stat_t;
endpackage

// ----- rtl/rpsl_lane.sv -----
`include "reactive_power_split_limiter_assert.svh"
// One converter: rating, availability and a bit-serial truncated root.
module rpsl_lane #(
  parameter int unsigned FracBits = rpsl_pkg::FracBitsDef,
  localparam int unsigned RadW = 30 + 2 * FracBits,
  localparam int unsigned RootW = RadW / 2,
  localparam int unsigned CntW = $clog2(RootW + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [15:0]     power_i,
  input  logic [5:0]             flags_i,
  input  logic [14:0]            full_i,
  input  logic [14:0]            half_i,
  output rpsl_pkg::lane_stat_t   stat_o,
  output logic [RootW-1:0]       root_o
);
  logic [1:0]       der_a, der_b;
  logic [14:0]      rating;
  logic [15:0]      p_abs;
  logic             avail;
  logic [29:0]      s_sq_q, p_sq_q, s_sq_d, p_sq_d;
  logic [RadW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] res_q, res_d;
  logic [RadW-1:0]  rad_q, rad_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, sq_q, sq_d, pos_q, pos_d;
  logic             avail_q, avail_d, done_q, done_d;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] top;

  assign der_a = flags_i[3:2];
  assign der_b = flags_i[5:4];
  always_comb begin
    if (der_a == rpsl_pkg::DerateAll || der_b == rpsl_pkg::DerateAll) begin
      rating = '0;
    end else if (der_a != 2'b00 || der_b != 2'b00) begin
      rating = half_i;
    end else begin
      rating = full_i;
    end
  end
  assign p_abs = power_i[15] ? 16'(-power_i) : 16'(power_i);
  assign avail = flags_i[0] & ~flags_i[1] & (rating != '0);

  // Restoring root: two radicand bits enter per cycle.
  assign top   = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
  assign trial = {res_q, 2'b01};

  always_comb begin
    s_sq_d = s_sq_q; p_sq_d = p_sq_q; rem_d = rem_q; res_d = res_q;
    rad_d = rad_q; cnt_d = cnt_q; busy_d = busy_q; sq_d = 1'b0;
    pos_d = pos_q; avail_d = avail_q; done_d = 1'b0;
    if (start_i) begin
      s_sq_d  = 30'(rating) * 30'(rating);
      p_sq_d  = 30'(p_abs) * 30'(p_abs);
      pos_d   = avail && ({1'b0, rating} > p_abs);
      avail_d = avail;
      sq_d    = 1'b1;
    end else if (sq_q) begin
      rad_d  = pos_q ? RadW'(s_sq_q - p_sq_q) << (2 * FracBits) : '0;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (top >= trial) begin
        rem_d = RadW'(top - trial);
        res_d = {res_q[RootW-2:0], 1'b1};
      end else begin
        rem_d = RadW'(top);
        res_d = {res_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; sq_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; sq_q <= sq_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    s_sq_q <= s_sq_d; p_sq_q <= p_sq_d; rem_q <= rem_d; res_q <= res_d;
    rad_q <= rad_d; pos_q <= pos_d; avail_q <= avail_d;
  end

  assign stat_o.valid = done_q;
  assign stat_o.avail = avail_q;
  assign root_o = res_q;

  `RPSL_ASSERT(a_lane_start_idle, clk_i, rst_ni, start_i |-> !busy_q && !sq_q, "lane restarted")
  `RPSL_ASSERT(a_lane_done_once, clk_i, rst_ni, done_q |=> !done_q, "double done")
  `RPSL_ASSERT(a_lane_sq_busy, clk_i, rst_ni, sq_q |=> busy_q, "root not started")
endmodule

// ----- rtl/rpsl_merge.sv -----
`include "reactive_power_split_limiter_assert.svh"
// Combines lane roots into group sums, limits and the group command.
module rpsl_merge #(
  parameter int unsigned FracBits = rpsl_pkg::FracBitsDef,
  localparam int unsigned RootW = (30 + 2 * FracBits) / 2,
  localparam int unsigned SumW = RootW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rpsl_pkg::lane_stat_t stat_i [rpsl_pkg::NumLanes],
  input  logic [RootW-1:0]     root_i [rpsl_pkg::NumLanes],
  input  logic signed [15:0]   req_i,
  output logic                 valid_o,
  output logic [15:0]          g1_cap_o,
  output logic [15:0]          g2_cap_o,
  output logic [1:0]           g1_cnt_o,
  output logic [1:0]           g2_cnt_o,
  output logic [15:0]          bal_o,
  output logic [16:0]          total_o,
  output logic signed [15:0]   cmd_o
);
  logic [SumW-1:0] s1_q, s2_q, r0, r1, r2, r3, bal;
  logic [1:0]      n1_q, n2_q;
  logic            v_q, neg_q;
  logic [16:0]     req_abs;
  logic [SumW+16:0] mag_full, mag_c;
  logic [SumW+16:0] mag_i;
  logic [SumW-FracBits:0] tot;

  assign r0 = stat_i[0].avail ? SumW'(root_i[0]) : '0;
  assign r1 = stat_i[1].avail ? SumW'(root_i[1]) : '0;
  assign r2 = stat_i[2].avail ? SumW'(root_i[2]) : '0;
  assign r3 = stat_i[3].avail ? SumW'(root_i[3]) : '0;

  // Register sums, then compute limits from them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= stat_i[0].valid;
    end
  end
  always_ff @(posedge clk_i) begin
    s1_q  <= r0 + r1;
    s2_q  <= r2 + r3;
    n1_q  <= 2'(stat_i[0].avail) + 2'(stat_i[1].avail);
    n2_q  <= 2'(stat_i[2].avail) + 2'(stat_i[3].avail);
    neg_q <= req_i[15];
    req_abs <= req_i[15] ? 17'(-{req_i[15], req_i}) : 17'({1'b0, req_i});
  end

  function automatic logic [15:0] sat16(input logic [SumW-1:0] fx);
    logic [SumW-1:0] v;
    v = fx >> FracBits;
    sat16 = (v > SumW'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction

  logic both;
  assign both = (n1_q != 2'd0) && (n2_q != 2'd0);
  assign bal  = both ? ((s1_q < s2_q) ? s1_q : s2_q) : '0;
  assign mag_full = (SumW+17)'(req_abs) << FracBits >> 1;
  assign mag_c = (mag_full > (SumW+17)'(bal)) ? (SumW+17)'(bal) : mag_full;
  assign mag_i = mag_c >> FracBits;
  assign tot = (SumW-FracBits+1)'(({1'b0, bal} << 1) >> FracBits);

  always_comb begin
    logic [15:0] m;
    m = 16'(mag_i);
    if (!neg_q && mag_i > (SumW+17)'(16'h7FFF)) m = 16'h7FFF;
    if (mag_i > (SumW+17)'(17'h8000)) m = 16'h8000;
    cmd_o = neg_q ? 16'(-m) : m;
  end

  assign valid_o  = v_q;
  assign g1_cap_o = sat16(s1_q);
  assign g2_cap_o = sat16(s2_q);
  assign g1_cnt_o = n1_q;
  assign g2_cnt_o = n2_q;
  assign bal_o    = sat16(bal);
  assign total_o  = (tot > (SumW-FracBits+1)'(17'h1FFFF)) ? 17'h1FFFF : 17'(tot);

  `RPSL_ASSERT(a_mrg_lanes, clk_i, rst_ni,
    stat_i[0].valid |-> stat_i[1].valid && stat_i[2].valid && stat_i[3].valid,
    "lanes out of step")
  `RPSL_ASSERT(a_mrg_cmd0, clk_i, rst_ni, valid_o && !both |-> cmd_o == 16'sd0, "cmd nonzero")
endmodule

// ----- rtl/reactive_power_split_limiter.sv -----
// Channel  | Handshake           | Payload
// request  | in_valid_i/ready_o  | total_q_request_i, pcsN_active_power_i, pcsN_flags_i
// result   | out_valid_o/ready_i | group capacities, counts, limits, group_command_o
// config   | APB psel/penable    | rated_full_kva (0x0), rated_half_kva (0x4)
// A request passes a square, a radicand load, the bit-serial root in each of
// four parallel root lanes, the merge register and the output register.
// A new request enters only once the last one has left the merge stage and
// the holding register is empty. While out_ready_i is low the output register
// holds its result and a second register catches the next one; hold the input
// while that register is full. Reset is asynchronous; ratings return to 2500
// and 1250.
`include "reactive_power_split_limiter_assert.svh"
module reactive_power_split_limiter #(
  parameter int unsigned FRAC_BITS = rpsl_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] total_q_request_i,
  input  logic signed [15:0] pcs1_active_power_i,
  input  logic signed [15:0] pcs2_active_power_i,
  input  logic signed [15:0] pcs3_active_power_i,
  input  logic signed [15:0] pcs4_active_power_i,
  input  logic [5:0]         pcs1_flags_i,
  input  logic [5:0]         pcs2_flags_i,
  input  logic [5:0]         pcs3_flags_i,
  input  logic [5:0]         pcs4_flags_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        group1_capacity_o,
  output logic [15:0]        group2_capacity_o,
  output logic [1:0]         group1_available_o,
  output logic [1:0]         group2_available_o,
  output logic [15:0]        balance_limit_o,
  output logic [16:0]        total_limit_o,
  output logic signed [15:0] group_command_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int unsigned RootW = (30 + 2 * FRAC_BITS) / 2;

  logic [14:0] full_q, half_q;
  logic        busy_q, busy_d, start, hold_q;
  logic signed [15:0] req_q;
  logic signed [15:0] pwr [rpsl_pkg::NumLanes];
  logic [5:0]  flg [rpsl_pkg::NumLanes];
  rpsl_pkg::lane_stat_t stat [rpsl_pkg::NumLanes];
  logic [RootW-1:0] root [rpsl_pkg::NumLanes];
  logic        m_valid;
  logic [15:0] m_g1, m_g2, m_bal;
  logic [1:0]  m_n1, m_n2;
  logic [16:0] m_tot;
  logic signed [15:0] m_cmd;
  logic [15:0] h_g1_q, h_g2_q, h_bal_q;
  logic [1:0]  h_n1_q, h_n2_q;
  logic [16:0] h_tot_q;
  logic signed [15:0] h_cmd_q;

  // Configuration registers; a write lands on the access phase.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= rpsl_pkg::FullReset;
      half_q <= rpsl_pkg::HalfReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == rpsl_pkg::RegFull) full_q <= pwdata[14:0];
      else half_q <= pwdata[14:0];
    end
  end
  assign prdata = (paddr[1:0] != 2'b00) ? '0 :
                  (paddr[2] == rpsl_pkg::RegFull) ? {17'd0, full_q} : {17'd0, half_q};

  // Accept while the lanes are free and the holding register is empty, so a
  // finished result always has a place to land.
  assign start      = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q && !hold_q;
  always_comb begin
    busy_d = busy_q;
    if (start) busy_d = 1'b1;
    else if (m_valid) busy_d = 1'b0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start) req_q <= total_q_request_i;
  end

  assign pwr[0] = pcs1_active_power_i; assign flg[0] = pcs1_flags_i;
  assign pwr[1] = pcs2_active_power_i; assign flg[1] = pcs2_flags_i;
  assign pwr[2] = pcs3_active_power_i; assign flg[2] = pcs3_flags_i;
  assign pwr[3] = pcs4_active_power_i; assign flg[3] = pcs4_flags_i;

  for (genvar g = 0; g < rpsl_pkg::NumLanes; g++) begin : g_lane
    rpsl_lane #(.FracBits(FRAC_BITS)) u_lane (
      .clk_i, .rst_ni, .start_i(start), .power_i(pwr[g]), .flags_i(flg[g]),
      .full_i(full_q), .half_i(half_q), .stat_o(stat[g]), .root_o(root[g])
    );
  end

  rpsl_merge #(.FracBits(FRAC_BITS)) u_merge (
    .clk_i, .rst_ni, .stat_i(stat), .root_i(root), .req_i(req_q),
    .valid_o(m_valid), .g1_cap_o(m_g1), .g2_cap_o(m_g2), .g1_cnt_o(m_n1),
    .g2_cnt_o(m_n2), .bal_o(m_bal), .total_o(m_tot), .cmd_o(m_cmd)
  );

  // Output register: hold while stalled and park a new result aside; when the
  // slot frees, advance the parked result first, else load the merge result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      hold_q      <= 1'b0;
    end else if (out_valid_o && !out_ready_i) begin
      if (m_valid) hold_q <= 1'b1;
    end else if (hold_q) begin
      out_valid_o <= 1'b1;
      hold_q      <= 1'b0;
    end else begin
      out_valid_o <= m_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (out_valid_o && !out_ready_i) begin
      if (m_valid) begin
        h_g1_q  <= m_g1;
        h_g2_q  <= m_g2;
        h_n1_q  <= m_n1;
        h_n2_q  <= m_n2;
        h_bal_q <= m_bal;
        h_tot_q <= m_tot;
        h_cmd_q <= m_cmd;
      end
    end else if (hold_q) begin
      group1_capacity_o  <= h_g1_q;
      group2_capacity_o  <= h_g2_q;
      group1_available_o <= h_n1_q;
      group2_available_o <= h_n2_q;
      balance_limit_o    <= h_bal_q;
      total_limit_o      <= h_tot_q;
      group_command_o    <= h_cmd_q;
    end else if (m_valid) begin
      group1_capacity_o  <= m_g1;
      group2_capacity_o  <= m_g2;
      group1_available_o <= m_n1;
      group2_available_o <= m_n2;
      balance_limit_o    <= m_bal;
      total_limit_o      <= m_tot;
      group_command_o    <= m_cmd;
    end
  end

  `RPSL_ASSERT(a_top_no_overrun, clk_i, rst_ni, m_valid |-> !hold_q, "result overwritten")
  `RPSL_ASSERT(a_top_busy, clk_i, rst_ni, start |=> busy_q, "busy not set")
  `RPSL_ASSERT(a_top_count, clk_i, rst_ni, m_valid |-> busy_q, "stray result")
endmodule

// ----- sim/rpsl_checker.sv -----
`timescale 1ns / 100ps
module rpsl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] total_q_request_i,
  input  logic signed [15:0] pcs1_active_power_i,
  input  logic signed [15:0] pcs2_active_power_i,
  input  logic signed [15:0] pcs3_active_power_i,
  input  logic signed [15:0] pcs4_active_power_i,
  input  logic [5:0]         pcs1_flags_i,
  input  logic [5:0]         pcs2_flags_i,
  input  logic [5:0]         pcs3_flags_i,
  input  logic [5:0]         pcs4_flags_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        group1_capacity_i,
  input  logic [15:0]        group2_capacity_i,
  input  logic [1:0]         group1_available_i,
  input  logic [1:0]         group2_available_i,
  input  logic [15:0]        balance_limit_i,
  input  logic [16:0]        total_limit_i,
  input  logic signed [15:0] group_command_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);
  typedef struct packed {
    logic [15:0] cap1;
    logic [15:0] cap2;
    logic [1:0]  n1;
    logic [1:0]  n2;
    logic [15:0] bal;
    logic [16:0] tot;
    logic [15:0] cmd;
  } split_t;

  split_t      split_q[$];
  logic [14:0] full_kva, half_kva;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Return 1 when the converter is available; accumulate its headroom.
  function automatic int lane_qmax(logic signed [15:0] p, logic [5:0] f, ref logic [63:0] acc);
    logic [63:0] s, pa;
    if (f[3:2] == rpsl_pkg::DerateAll || f[5:4] == rpsl_pkg::DerateAll) s = 0;
    else if (f[5:2] != 0) s = half_kva;
    else s = full_kva;
    pa = (p < 0) ? 64'(-32'(p)) : 64'(p);
    if (!f[0] || f[1] || s == 0) return 0;
    if (pa < s) acc += root_floor((s * s - pa * pa) << 16);
    return 1;
  endfunction

  function automatic logic [15:0] sat_int(logic [63:0] fx);
    return (fx >> 8) > 64'hFFFF ? 16'hFFFF : 16'(fx >> 8);
  endfunction

  function automatic split_t predict_split();
    split_t      e;
    logic [63:0] g1, g2, bal, mag;
    int          n1, n2;
    g1 = 0;
    g2 = 0;
    bal = 0;
    e = '0;
    n1 = lane_qmax(pcs1_active_power_i, pcs1_flags_i, g1)
       + lane_qmax(pcs2_active_power_i, pcs2_flags_i, g1);
    n2 = lane_qmax(pcs3_active_power_i, pcs3_flags_i, g2)
       + lane_qmax(pcs4_active_power_i, pcs4_flags_i, g2);
    if (n1 != 0 && n2 != 0) begin
      bal = g1 < g2 ? g1 : g2;
      e.tot = ((bal * 2) >> 8) > 64'h1FFFF ? 17'h1FFFF : 17'((bal * 2) >> 8);
      mag = total_q_request_i < 0 ? 64'(-32'(total_q_request_i)) : 64'(total_q_request_i);
      mag = (mag << 8) >> 1;
      if (mag > bal) mag = bal;
      mag >>= 8;
      if (mag > 64'h7FFF && total_q_request_i >= 0) mag = 64'h7FFF;
      if (mag > 64'h8000) mag = 64'h8000;
      e.cmd = total_q_request_i < 0 ? 16'(-mag) : 16'(mag);
    end
    e.cap1 = sat_int(g1);
    e.cap2 = sat_int(g2);
    e.n1 = 2'(n1);
    e.n2 = 2'(n2);
    e.bal = sat_int(bal);
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at %0t: got %0h want %0h", what, $realtime, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    split_t e;
    if (!rst_ni) begin
      full_kva <= rpsl_pkg::FullReset;
      half_kva <= rpsl_pkg::HalfReset;
      errors_o = 0;
      results_o = 0;
      split_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) split_q.push_back(predict_split());
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (split_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = split_q.pop_front();
          if (group1_capacity_i !== e.cap1) report_mismatch("group1_capacity", group1_capacity_i, e.cap1);
          if (group2_capacity_i !== e.cap2) report_mismatch("group2_capacity", group2_capacity_i, e.cap2);
          if (group1_available_i !== e.n1) report_mismatch("group1_available", group1_available_i, e.n1);
          if (group2_available_i !== e.n2) report_mismatch("group2_available", group2_available_i, e.n2);
          if (balance_limit_i !== e.bal) report_mismatch("balance_limit", balance_limit_i, e.bal);
          if (total_limit_i !== e.tot) report_mismatch("total_limit", total_limit_i, e.tot);
          if (group_command_i !== e.cmd) report_mismatch("group_command", group_command_i, e.cmd);
        end
      end
      if (cfg_we_i) begin
        if (cfg_addr_i == 3'(4 * rpsl_pkg::RegFull)) full_kva <= cfg_wdata_i[14:0];
        else if (cfg_addr_i == 3'(4 * rpsl_pkg::RegHalf)) half_kva <= cfg_wdata_i[14:0];
      end
    end
  end

  assign pending_o = split_q.size();
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic signed [15:0] q_req = 0, p1 = 0, p2 = 0, p3 = 0, p4 = 0;
  logic [5:0] f1 = 0, f2 = 0, f3 = 0, f4 = 0;
  logic [15:0] cap1, cap2, bal;
  logic [1:0] n1, n2;
  logic [16:0] tot;
  logic signed [15:0] cmd;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int errors, pending, results, cycles = 0;
  bit hold_off = 0;    // long receiver stall requested by the stimulus
  bit sending_done = 0;

  always #6 clk_i = ~clk_i;

  reactive_power_split_limiter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .total_q_request_i(q_req),
    .pcs1_active_power_i(p1), .pcs2_active_power_i(p2),
    .pcs3_active_power_i(p3), .pcs4_active_power_i(p4),
    .pcs1_flags_i(f1), .pcs2_flags_i(f2), .pcs3_flags_i(f3), .pcs4_flags_i(f4),
    .out_valid_o, .out_ready_i,
    .group1_capacity_o(cap1), .group2_capacity_o(cap2),
    .group1_available_o(n1), .group2_available_o(n2),
    .balance_limit_o(bal), .total_limit_o(tot), .group_command_o(cmd),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rpsl_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .total_q_request_i(q_req),
    .pcs1_active_power_i(p1), .pcs2_active_power_i(p2),
    .pcs3_active_power_i(p3), .pcs4_active_power_i(p4),
    .pcs1_flags_i(f1), .pcs2_flags_i(f2), .pcs3_flags_i(f3), .pcs4_flags_i(f4),
    .out_valid_i(out_valid_o), .out_ready_i,
    .group1_capacity_i(cap1), .group2_capacity_i(cap2),
    .group1_available_i(n1), .group2_available_i(n2),
    .balance_limit_i(bal), .total_limit_i(tot), .group_command_i(cmd),
    .cfg_we_i(psel && penable && pwrite && pready), .cfg_addr_i(paddr),
    .cfg_wdata_i(pwdata),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // Abort on a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls per result, plus one long hold-off on request.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      w = $urandom_range(0, 9);
      if (results > 400 && results < 500) w = 0;  // a stretch with no stalls
      if (w != 0) begin
        out_ready_i <= 0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o && !hold_off) @(posedge clk_i);
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Drop the request valid, then wait for every result.
  task automatic wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one request, holding it until accepted.
  task automatic send_request(logic signed [15:0] q, logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c, logic signed [15:0] d,
                              logic [5:0] fa, logic [5:0] fb, logic [5:0] fc, logic [5:0] fd,
                              bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 9);
    if (w != 0) begin
      in_valid_i <= 0;
      repeat (w) @(posedge clk_i);
    end
    in_valid_i <= 1;
    q_req <= q; p1 <= a; p2 <= b; p3 <= c; p4 <= d;
    f1 <= fa; f2 <= fb; f3 <= fc; f4 <= fd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [5:0] healthy_flags();
    // Mostly run, no fault; derating random but rarely both pairs off.
    logic [5:0] f;
    f = 6'($urandom);
    f[0] = ($urandom_range(0, 9) != 0);
    f[1] = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) f[5:2] = 0;
    return f;
  endfunction

  function automatic logic signed [15:0] moderate_power(int s);
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($urandom_range(0, s + s / 4)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
  endfunction

  initial begin
    logic [14:0] full_set[6] = '{15'd2500, 15'd32767, 15'd0, 15'd1, 15'd30000, 15'd700};
    logic [14:0] half_set[6] = '{15'd1250, 15'd32767, 15'd500, 15'd0, 15'd1, 15'd350};
    int s;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, empty groups, derate codes, P at/above rating.
    send_request(16'sh7FFF, 0, 0, 0, 0, 6'h01, 6'h01, 6'h01, 6'h01, 0);
    send_request(16'sh8000, 0, 0, 0, 0, 6'h01, 6'h01, 6'h01, 6'h01, 0);
    send_request(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                 6'h01, 6'h01, 6'h01, 6'h01, 0);
    send_request(100, 2500, -2500, 2499, -1, 6'h01, 6'h01, 6'h01, 6'h01, 0);
    send_request(-100, 0, 0, 0, 0, 6'h00, 6'h03, 6'h01, 6'h01, 0);
    send_request(500, 0, 0, 0, 0, 6'h01, 6'h01, 6'h02, 6'h00, 0);
    send_request(-1, 0, 0, 0, 0, 6'h0D, 6'h31, 6'h05, 6'h11, 0);
    send_request(1, 100, 200, 300, 400, 6'h09, 6'h21, 6'h15, 6'h3F, 0);
    send_request(-3000, 1250, 1249, 0, 0, 6'h05, 6'h01, 6'h01, 6'h01, 0);
    send_request(0, 0, 0, 0, 0, 6'h3F, 6'h3E, 6'h01, 6'h01, 0);
    wait_drained();
    apb_write(3'(4 * rpsl_pkg::RegFull), 32'h7FFF);
    apb_write(3'(4 * rpsl_pkg::RegHalf), 32'hFFFF_FFFF);
    send_request(16'sh7FFF, 0, 0, 0, 0, 6'h01, 6'h01, 6'h01, 6'h01, 0);
    send_request(16'sh8000, 0, 1, 0, 0, 6'h05, 6'h01, 6'h01, 6'h01, 0);
    send_request(-32767, 16'sh8000, 0, 0, 0, 6'h01, 6'h01, 6'h01, 6'h11, 0);

    // Random phases, each with its own rating pair.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      apb_write(3'(4 * rpsl_pkg::RegFull), {17'($urandom), full_set[ph]});
      apb_write(3'(4 * rpsl_pkg::RegHalf), {17'($urandom), half_set[ph]});
      s = full_set[ph];
      for (int i = 0; i < 190; i++) begin
        if (ph == 2 && i == 50) begin
          hold_off = 1;  // receiver stalls; keep offering back to back
          for (int k = 0; k < 12; k++)
            send_request(16'($urandom), moderate_power(s), moderate_power(s),
                         moderate_power(s), moderate_power(s),
                         healthy_flags(), healthy_flags(), healthy_flags(), healthy_flags(), 1);
        end
        if (ph == 4 && i == 100) begin
          in_valid_i <= 0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_request(($urandom_range(0, 3) == 0) ? 16'($urandom)
                       : 16'($urandom_range(0, 2 * s)) * (($urandom_range(0, 1) != 0) ? 1 : -1),
                     moderate_power(s), moderate_power(s), moderate_power(s), moderate_power(s),
                     healthy_flags(), healthy_flags(), healthy_flags(), healthy_flags(), 0);
      end
    end
    in_valid_i <= 0;
    sending_done = 1;
    wait_drained();

    $display("Covered %0d results over directed extremes and six rating settings,", results);
    $display("with random stalls, a long output hold-off and a drained pause.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rpsl_pkg.sv
rtl/rpsl_lane.sv
rtl/rpsl_merge.sv
rtl/reactive_power_split_limiter.sv
sim/rpsl_checker.sv
sim/testbench.sv
